// ===== design/bafs_pkg.sv =====
`timescale 1ns / 1ps

package bafs_pkg;

	localparam int MAX_BITS   = 4096;
	localparam int WORD_COUNT = 64;
	localparam int WORD_SHIFT = 6;
	localparam int WORD_BITS  = 1 << WORD_SHIFT;

	// widths of the item fields are fixed
	localparam int SIZE_W = 13;
	localparam int BIDX_W = 12;
	localparam int EIDX_W = 13;

	localparam int WADDR_W = $clog2(WORD_COUNT);
	localparam int WCNT_W  = $clog2(WORD_COUNT + 1);
	localparam int OFF_W   = $clog2(WORD_BITS + 1);

	typedef logic [WORD_BITS-1:0] word_t;

	typedef enum logic [1:0] {
		MODE_FIND  = 2'd0,
		MODE_SET   = 2'd1,
		MODE_CLEAR = 2'd2,
		MODE_FILL  = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t             mode;
		logic [BIDX_W-1:0] bit_index;
		logic [EIDX_W-1:0] end_index;
	} in_item_t;

	typedef struct packed {
		logic [SIZE_W-1:0] found_index;
		logic              not_found;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_PRESENT
	} ctl_state_t;

	typedef struct packed {
		logic load;
		logic issue;
		logic finish;
		logic present;
	} ctl_cmd_t;

	typedef struct packed {
		logic more;
		logic act;
		logic hit;
	} ctl_stat_t;

endpackage

// ===== design/bafs_ctrl.sv =====
`timescale 1ns / 1ps

module bafs_ctrl import bafs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	input  ctl_stat_t stat,
	output ctl_cmd_t  cmd
);

	ctl_state_t state_q, state_d;
	logic       out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_RUN;
				end
			end
			ST_RUN: begin
				// stop issuing once a clear bit has been seen
				cmd.issue = stat.more && !stat.hit;
				if (stat.hit || (!stat.more && !stat.act)) begin
					cmd.finish = 1'b1;
					state_d    = ST_PRESENT;
				end
			end
			ST_PRESENT: begin
				if (!out_valid_q || rsp_ready) begin
					cmd.present = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		out_valid_d = cmd.present ? 1'b1 : (out_valid_q && !rsp_ready);
	end

	assign rsp_valid = out_valid_q;

endmodule

// ===== design/bafs_dp.sv =====
`timescale 1ns / 1ps

module bafs_dp import bafs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  ctl_cmd_t          cmd,
	output ctl_stat_t         stat,
	input  in_item_t          req,
	input  logic              cfg_we,
	input  logic [SIZE_W-1:0] cfg_data,
	output out_item_t         rsp
);

	function automatic word_t ones_below(input logic [OFF_W-1:0] n);
		word_t r;
		if (n >= OFF_W'(WORD_BITS)) r = '1;
		else r = (word_t'(1) << n[WORD_SHIFT-1:0]) - word_t'(1);
		return r;
	endfunction

	function automatic logic [WORD_SHIFT-1:0] lowest_one(input word_t v);
		logic [WORD_SHIFT-1:0] r;
		r = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (v[i]) r = WORD_SHIFT'(i);
		end
		return r;
	endfunction

	// configuration and derived bounds
	logic [SIZE_W-1:0] size_q, eff;
	logic [SIZE_W:0]   wiu_wide;
	logic [WCNT_W-1:0] wiu;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) size_q <= SIZE_W'(MAX_BITS);
		else if (cfg_we) size_q <= cfg_data;
	end

	always_comb begin
		eff      = (size_q > SIZE_W'(MAX_BITS)) ? SIZE_W'(MAX_BITS) : size_q;
		wiu_wide = ({1'b0, eff} + (SIZE_W + 1)'(WORD_BITS - 1)) >> WORD_SHIFT;
		wiu      = (wiu_wide > (SIZE_W + 1)'(WORD_COUNT)) ? WCNT_W'(WORD_COUNT)
		                                                  : WCNT_W'(wiu_wide);
	end

	// item registers and word walk
	mode_t             mode_q;
	logic [BIDX_W-1:0] bi_q;
	logic [EIDX_W-1:0] ei_q;
	logic [WCNT_W-1:0] word_q, limit_q, start_c, limit_c;
	logic [SIZE_W-1:0] s13;
	logic [EIDX_W:0]   ceil_wide;

	always_comb begin
		s13       = SIZE_W'(req.bit_index);
		ceil_wide = ({1'b0, req.end_index} + (EIDX_W + 1)'(WORD_BITS - 1)) >> WORD_SHIFT;
		start_c   = '0;
		limit_c   = '0;
		unique case (req.mode)
			MODE_FIND: limit_c = wiu;
			MODE_SET, MODE_CLEAR: begin
				if (s13 < eff) begin
					start_c = WCNT_W'(req.bit_index >> WORD_SHIFT);
					limit_c = start_c + WCNT_W'(1);
				end
			end
			MODE_FILL: begin
				if (req.end_index > s13) begin
					start_c = WCNT_W'(req.bit_index >> WORD_SHIFT);
					limit_c = (ceil_wide < (EIDX_W + 1)'(wiu)) ? WCNT_W'(ceil_wide) : wiu;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= req.mode;
			bi_q    <= req.bit_index;
			ei_q    <= req.end_index;
			limit_q <= limit_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) word_q <= '0;
		else if (cmd.load) word_q <= start_c;
		else if (cmd.issue) word_q <= word_q + WCNT_W'(1);
	end

	// word store: valid bits stand for the all-zero reset
	word_t               mem [WORD_COUNT];
	logic [WORD_COUNT-1:0] vld_q;
	word_t               rd_s1;
	logic                rd_vld_s1, act_s1;
	logic [WADDR_W-1:0]  addr_s1;
	logic                we;
	word_t               old_w, new_w, pmask, bitm;

	always_ff @(posedge clk) begin
		if (we) mem[addr_s1] <= new_w;
		if (cmd.issue) begin
			rd_s1   <= mem[word_q[WADDR_W-1:0]];
			addr_s1 <= word_q[WADDR_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			act_s1    <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			act_s1 <= cmd.issue;
			if (cmd.issue) rd_vld_s1 <= vld_q[word_q[WADDR_W-1:0]];
			if (we) vld_q[addr_s1] <= 1'b1;
		end
	end

	// modify the word read in stage one
	logic [SIZE_W-1:0] base, base_end, bi13, hiv;
	logic [OFF_W-1:0]  lo_off, hi_off;
	logic              full;

	always_comb begin
		old_w    = rd_vld_s1 ? rd_s1 : '0;
		base     = SIZE_W'({addr_s1, {WORD_SHIFT{1'b0}}});
		base_end = base + SIZE_W'(WORD_BITS);
		bi13     = SIZE_W'(bi_q);
		hiv      = (ei_q < eff) ? ei_q : eff;
		lo_off   = (bi13 > base) ? OFF_W'(bi13 - base) : '0;
		if (hiv >= base_end) hi_off = OFF_W'(WORD_BITS);
		else if (hiv > base) hi_off = OFF_W'(hiv - base);
		else hi_off = '0;
		full     = (bi13 <= base) && (ei_q >= base_end);
		pmask    = ones_below(hi_off) & ~ones_below(lo_off);
		bitm     = word_t'(1) << bi_q[WORD_SHIFT-1:0];
		unique case (mode_q)
			MODE_SET:   new_w = old_w | bitm;
			MODE_CLEAR: new_w = old_w & ~bitm;
			MODE_FILL:  new_w = full ? '1 : (old_w | pmask);
			MODE_FIND:  new_w = old_w;
			default:    new_w = old_w;
		endcase
		we = act_s1 && (mode_q != MODE_FIND);
	end

	// status and result
	logic              hit;
	logic [SIZE_W-1:0] found_c;
	out_item_t         res_q, out_q;

	assign hit = act_s1 && (mode_q == MODE_FIND) && (~old_w != '0);

	always_comb begin
		stat.more = word_q < limit_q;
		stat.act  = act_s1;
		stat.hit  = hit;
		if (hit) found_c = SIZE_W'({addr_s1, lowest_one(~old_w)});
		else found_c = SIZE_W'({limit_q, {WORD_SHIFT{1'b0}}});
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (mode_q == MODE_FIND) begin
				res_q.found_index <= found_c;
				res_q.not_found   <= found_c >= eff;
			end else begin
				res_q <= '0;
			end
		end
		if (cmd.present) out_q <= res_q;
	end

	assign rsp = out_q;

endmodule

// ===== design/bitmap_allocator_find_set_clear.sv =====
`timescale 1ns / 1ps

// Bitmap allocator over 64 words of 64 bits, all clear after reset. Each
// request item gives exactly one response item. The store is walked one word
// per cycle through a single read port with a registered read, so the time
// for an item is set by the number of words visited. Find-first-zero reads
// the words up to and including the first word with a clear bit, or all W
// words in use (ceil(size_in_bits / 64), at most 64) when it finds none;
// fill-range reads and writes the N words it touches; set-bit and clear-bit
// touch one word; a request may touch no word at all. Requests are taken one
// at a time; a response waits in its own output register, so the next
// request may be taken while it stands.
// The size register is written through its own channel, which is always
// ready, and must only be written while no request is in flight.

module bitmap_allocator_find_set_clear import bafs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  in_item_t          req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output out_item_t         rsp,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [SIZE_W-1:0] cfg_data
);

	ctl_cmd_t  cmd;
	ctl_stat_t stat;

	// configuration writes never stall
	assign cfg_ready = 1'b1;

	// sequencing: accept, walk the words, hold the response
	bafs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// word store, read-modify-write path, scan and result registers
	bafs_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.req      (req),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.rsp      (rsp)
	);

endmodule

// ===== test/bitmap_allocator_find_set_clear_tb.sv =====
`timescale 1ns / 1ps

module bitmap_allocator_find_set_clear_tb;
	import bafs_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned MAX_GAP     = 17;
	localparam int unsigned SETTLE      = 80;   // > longest walk over 64 words

	logic              clk = 1'b0;
	logic              arst_n;
	logic              req_valid;
	logic              req_ready;
	in_item_t          req;
	logic              rsp_valid;
	logic              rsp_ready;
	out_item_t         rsp;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [SIZE_W-1:0] cfg_data;

	// Shadow of the allocator: word store and size register
	logic [WORD_BITS-1:0] shadow_words [WORD_COUNT];
	logic [SIZE_W-1:0]    shadow_size;

	// Responses the allocator owes, oldest first
	out_item_t bitmap_answers[$];

	int unsigned cycle_count = 0;
	int unsigned n_errors    = 0;
	int unsigned n_checked   = 0;
	int unsigned n_full_find = 0;
	int unsigned n_size_wr   = 0;
	int unsigned mode_seen [4];
	int unsigned rx_hold     = 0;   // long hold-off, counted down by the sink
	bit          rx_steady   = 1'b0;
	bit          tx_steady   = 1'b0;
	bit          offering    = 1'b0; // req_valid is (or is about to be) high

	bitmap_allocator_find_set_clear DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d responses outstanding",
				cycle_count, bitmap_answers.size());
			$display("[bitmap_allocator_find_set_clear] ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Shadow model
	// ------------------------------------------------------------------

	// Sizes above the store's capacity behave as the full capacity
	function automatic int unsigned live_bits();
		return (shadow_size > MAX_BITS) ? MAX_BITS : shadow_size;
	endfunction

	function automatic int unsigned live_words();
		int unsigned w;
		w = (live_bits() + WORD_BITS - 1) >> WORD_SHIFT;
		return (w > WORD_COUNT) ? WORD_COUNT : w;
	endfunction

	// Single-bit write; indices at or above the size are dropped
	function automatic void poke_bit(int unsigned idx, bit one);
		if (idx >= live_bits())
			return;
		shadow_words[idx >> WORD_SHIFT][idx % WORD_BITS] = one;
	endfunction

	// Head bits up to a word boundary, whole words, then tail bits.
	// A whole word inside the live words goes to all ones, spare bits too.
	function automatic void fill_span(int unsigned lo, int unsigned hi);
		int unsigned s;
		s = lo;
		while ((s % WORD_BITS) != 0 && s < hi) begin
			poke_bit(s, 1'b1);
			s++;
		end
		while (s < hi && hi - s >= WORD_BITS) begin
			if ((s >> WORD_SHIFT) < live_words())
				shadow_words[s >> WORD_SHIFT] = '1;
			s += WORD_BITS;
		end
		while (s < hi) begin
			poke_bit(s, 1'b1);
			s++;
		end
	endfunction

	// Lowest clear bit among the live words, or live words * 64 if none
	function automatic int unsigned first_clear();
		int unsigned n;
		n = live_words();
		for (int unsigned w = 0; w < n; w++) begin
			if (~shadow_words[w] != '0) begin
				for (int unsigned b = 0; b < WORD_BITS; b++) begin
					if (!shadow_words[w][b])
						return w * WORD_BITS + b;
				end
			end
		end
		return n * WORD_BITS;
	endfunction

	// Apply one request to the shadow and return the response it owes
	function automatic out_item_t bitmap_apply(in_item_t r);
		out_item_t a;
		int unsigned hit;
		a = '0;
		case (r.mode)
			MODE_FIND: begin
				hit = first_clear();
				a.found_index = SIZE_W'(hit);
				a.not_found   = (hit >= live_bits());
			end
			MODE_SET:   poke_bit(r.bit_index, 1'b1);
			MODE_CLEAR: poke_bit(r.bit_index, 1'b0);
			default:    fill_span(r.bit_index, r.end_index);
		endcase
		return a;
	endfunction

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------

	// Offer one item after a random gap, hold it until taken, then
	// record what the allocator owes for it
	task automatic send_req(input in_item_t r);
		int unsigned gap;
		gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			if (offering)
				req_valid <= 1'b0;
			offering = 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		offering   = 1'b1;
		do @(posedge clk); while (!req_ready);
		bitmap_answers.push_back(bitmap_apply(r));
		mode_seen[r.mode]++;
		if (r.mode == MODE_FIND && bitmap_answers[$].not_found)
			n_full_find++;
	endtask

	function automatic in_item_t make_req(mode_t m, int unsigned bi, int unsigned ei);
		in_item_t r;
		r.mode      = m;
		r.bit_index = BIDX_W'(bi);
		r.end_index = EIDX_W'(ei);
		return r;
	endfunction

	// Stop offering and wait until every owed response has come back
	task automatic drain();
		if (offering)
			req_valid <= 1'b0;
		offering = 1'b0;
		while (bitmap_answers.size() != 0) @(posedge clk);
	endtask

	// Write the size register; only ever with the allocator idle
	task automatic write_size(input int unsigned v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= SIZE_W'(v);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		shadow_size = SIZE_W'(v);
		n_size_wr++;
	endtask

	// Mostly indices up to just past the live size so the map fills and finds run deep;
	// some fully random fields, some long fills, empty and reversed ranges
	function automatic in_item_t random_req();
		in_item_t r;
		int unsigned span, pick;
		span = live_bits() + 8;
		if (span > 4095)
			span = 4095;
		pick = $urandom_range(0, 99);
		if (pick < 25)
			r.mode = MODE_FIND;
		else if (pick < 55)
			r.mode = MODE_SET;
		else if (pick < 70)
			r.mode = MODE_CLEAR;
		else
			r.mode = MODE_FILL;
		if ($urandom_range(0, 9) < 7)
			r.bit_index = BIDX_W'($urandom_range(0, span));
		else
			r.bit_index = BIDX_W'($urandom);
		r.end_index = EIDX_W'($urandom);
		if (r.mode == MODE_FILL) begin
			pick = $urandom_range(0, 99);
			if (pick < 55)
				r.end_index = EIDX_W'(r.bit_index + $urandom_range(0, 150));
			else if (pick < 70)
				r.end_index = EIDX_W'(r.bit_index + $urandom_range(0, 3));
			else if (pick < 80)
				r.end_index = EIDX_W'($urandom_range(0, r.bit_index));
			else if (pick < 88) begin
				r.bit_index = BIDX_W'($urandom_range(0, 200));
				r.end_index = EIDX_W'($urandom_range(1000, MAX_BITS));
			end
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Response side: random stalls, steady stretches, one long hold-off
	// ------------------------------------------------------------------
	initial begin : rsp_sink
		out_item_t   want;
		int unsigned stall;
		stall     = 0;
		rsp_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready) begin
				if (bitmap_answers.size() == 0) begin
					$error("response with nothing owed: found_index=%0d not_found=%0b",
						rsp.found_index, rsp.not_found);
					n_errors++;
				end else begin
					want = bitmap_answers.pop_front();
					if (rsp.found_index !== want.found_index) begin
						$error("found_index: expected %0d, actual %0d",
							want.found_index, rsp.found_index);
						n_errors++;
					end
					if (rsp.not_found !== want.not_found) begin
						$error("not_found: expected %0b, actual %0b",
							want.not_found, rsp.not_found);
						n_errors++;
					end
					n_checked++;
				end
				stall = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
			end
			// stalls only count while a response is on offer
			if (rx_hold != 0) begin
				rx_hold--;
				rsp_ready <= 1'b0;
			end else if (stall != 0) begin
				if (rsp_valid)
					stall--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// A cleared map answers bit 0
	task automatic test_reset_state();
		send_req(make_req(MODE_FIND, 0, 0));
	endtask

	// Both ends of the index range, set then clear
	task automatic test_set_clear();
		send_req(make_req(MODE_SET, 0, 0));
		send_req(make_req(MODE_SET, 4095, 8191));
		send_req(make_req(MODE_FIND, 4095, 8191));
		send_req(make_req(MODE_CLEAR, 0, 0));
		send_req(make_req(MODE_CLEAR, 4095, 0));
		send_req(make_req(MODE_FIND, 0, 0));
	endtask

	// Head, whole words and tail; empty and reversed ranges; a tail that
	// runs past the size
	task automatic test_fill_range();
		send_req(make_req(MODE_FILL, 3, 200));
		send_req(make_req(MODE_FIND, 0, 0));
		send_req(make_req(MODE_FILL, 0, 3));
		send_req(make_req(MODE_FIND, 0, 0));
		send_req(make_req(MODE_FILL, 300, 300));
		send_req(make_req(MODE_FILL, 500, 10));
		send_req(make_req(MODE_FILL, 4000, 8191));
	endtask

	// Zero size, bits out of range, spare bits in the last live word,
	// a whole-word fill over them, and a size above the capacity
	task automatic test_size_edges();
		write_size(0);
		send_req(make_req(MODE_FIND, 0, 0));
		send_req(make_req(MODE_SET, 5, 0));
		write_size(65);
		send_req(make_req(MODE_CLEAR, 64, 0));
		send_req(make_req(MODE_FIND, 0, 0));
		write_size(200);
		send_req(make_req(MODE_CLEAR, 120, 0));
		write_size(65);
		send_req(make_req(MODE_FIND, 0, 0));
		send_req(make_req(MODE_SET, 64, 0));
		send_req(make_req(MODE_FIND, 0, 0));
		send_req(make_req(MODE_SET, 120, 0));
		send_req(make_req(MODE_FIND, 0, 0));
		send_req(make_req(MODE_FILL, 64, 128));
		send_req(make_req(MODE_FIND, 0, 0));
		write_size(8191);
		send_req(make_req(MODE_FIND, 0, 0));
	endtask

	// Hold the sink off long enough for the allocator to back up into
	// its request side, keep offering items back to back, then drain
	task automatic test_backpressure();
		drain();
		rx_hold   = 400;
		tx_steady = 1'b1;
		for (int i = 0; i < 12; i++)
			send_req(random_req());
		tx_steady = 1'b0;
		drain();
	endtask

	// Random phases over a spread of sizes, extremes among them
	task automatic test_random();
		int unsigned sizes [9];
		sizes = '{1, 64, 65, 130, 700, MAX_BITS, 8191,
			$urandom_range(1, MAX_BITS), $urandom_range(0, 8191)};
		foreach (sizes[p]) begin
			write_size(sizes[p]);
			for (int i = 0; i < 150; i++) begin
				// flip into and out of stretches with no idling
				if ($urandom_range(0, 39) == 0)
					tx_steady = !tx_steady;
				if ($urandom_range(0, 39) == 0)
					rx_steady = !rx_steady;
				send_req(random_req());
			end
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	initial begin
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		shadow_size = SIZE_W'(MAX_BITS);
		foreach (shadow_words[w])
			shadow_words[w] = '0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_set_clear();
		test_fill_range();
		test_size_edges();
		test_backpressure();
		test_random();

		// let anything stray show up before judging
		drain();
		repeat (SETTLE) @(posedge clk);

		$display("checked %0d responses: %0d find (%0d with no free bit), %0d set,",
			n_checked, mode_seen[MODE_FIND], n_full_find, mode_seen[MODE_SET]);
		$display("%0d clear, %0d fill, over %0d size settings; %0d mismatches",
			mode_seen[MODE_CLEAR], mode_seen[MODE_FILL], n_size_wr, n_errors);
		if (n_errors == 0)
			$display("[bitmap_allocator_find_set_clear] OK");
		else
			$display("[bitmap_allocator_find_set_clear] ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/bafs_pkg.sv
design/bafs_ctrl.sv
design/bafs_dp.sv
design/bitmap_allocator_find_set_clear.sv
test/bitmap_allocator_find_set_clear_tb.sv
